[src/assert_macros.svh]
// assertion macros shared by the quaternion to euler angle design
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define QTE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define QTE_ASSERT_IMP(lbl, ante, cons, msg) \
  `QTE_ASSERT(lbl, (ante) |-> (cons), msg)
`else
`define QTE_ASSERT(lbl, prop, msg)
`define QTE_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

[src/qte_pkg.sv]
// shared types, constants and helpers of the quaternion to euler angle design
package qte_pkg;

  localparam int QUAT_FRAC_BITS_DEF = 14;
  localparam int CFG_W              = 14;
  localparam logic [CFG_W-1:0] POLE_THRESHOLD_RST = 14'd8190;

  localparam int CORDIC_STEPS = 16;
  localparam int ZW           = 20;
  localparam int XW           = 33;
  localparam int NORM_BITS    = 30;
  localparam int PI_Q16       = 205887;
  localparam int HALF_PI_Q12  = 6434;
  localparam int ATAN_TAB [CORDIC_STEPS] = '{
    51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2
  };

  localparam int ROOT_W = 31;
  localparam int RAD_W  = 2 * ROOT_W - 1;
  localparam int S30_W  = 32;
  localparam int ANG_W  = 16;
  localparam int PITCH_W = 14;

  typedef enum logic [1:0] {
    POLE_NONE  = 2'd0,
    POLE_NORTH = 2'd1,
    POLE_SOUTH = 2'd2
  } pole_case_e;

  typedef struct packed {
    logic zero;
    logic sa;
    logic sb;
    logic dbl;
    logic neg;
  } atan_side_t;

  typedef struct packed {
    pole_case_e                  pcase;
    logic signed [ANG_W-1:0]     yaw;
    logic signed [PITCH_W-1:0]   pitch;
    logic signed [ANG_W-1:0]     roll;
  } result_t;

  function automatic int max_int(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  // register stages of one atan2 unit for a given operand width
  function automatic int atan_lat(input int in_w);
    int nw;
    nw = max_int(in_w, NORM_BITS);
    return $clog2(nw) + CORDIC_STEPS + 3;
  endfunction

endpackage

[src/qte_atan2.sv]
// pipelined atan2 unit: magnitude, normalize, cordic vectoring, quadrant and rounding
module qte_atan2 #(
  parameter int IN_W = 35
) (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic signed [IN_W-1:0]          a_i,
  input  logic signed [IN_W-1:0]          b_i,
  input  logic                            dbl_i,
  input  logic                            neg_i,
  output logic signed [qte_pkg::ANG_W-1:0] angle_o
);

  localparam int NW = qte_pkg::max_int(IN_W, qte_pkg::NORM_BITS);
  localparam int NS = $clog2(NW);
  localparam int NB = qte_pkg::NORM_BITS;
  localparam int XW = qte_pkg::XW;
  localparam int ZW = qte_pkg::ZW;
  localparam int ST = qte_pkg::CORDIC_STEPS;
  localparam int VW = ZW + 3;

  logic [IN_W-1:0]          ua, ub;
  logic [NW-1:0]            na_q [NS+1];
  logic [NW-1:0]            nb_q [NS+1];
  qte_pkg::atan_side_t      ns_q [NS+1];
  logic signed [XW-1:0]     cx_q [ST];
  logic signed [XW-1:0]     cy_q [ST];
  logic signed [ZW-1:0]     cz_q [ST];
  qte_pkg::atan_side_t      cs_q [ST];
  logic signed [ZW-1:0]     zq_d, zq_q;
  qte_pkg::atan_side_t      qs_q;
  logic signed [VW-1:0]     v, r;
  logic signed [qte_pkg::ANG_W-1:0] ang_q;

  assign ua = a_i[IN_W-1] ? IN_W'(-a_i) : IN_W'(a_i);
  assign ub = b_i[IN_W-1] ? IN_W'(-b_i) : IN_W'(b_i);

  // magnitudes and signs
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      na_q[0]      <= NW'(ua);
      nb_q[0]      <= NW'(ub);
      ns_q[0].zero <= (a_i == '0) && (b_i == '0);
      ns_q[0].sa   <= a_i[IN_W-1];
      ns_q[0].sb   <= b_i[IN_W-1];
      ns_q[0].dbl  <= dbl_i;
      ns_q[0].neg  <= neg_i;
    end
  end

  // leading one search, one shift amount per stage
  for (genvar k = 0; k < NS; k++) begin : g_norm
    localparam int SA = 1 << (NS - 1 - k);
    logic [NW-1:0] orv;
    assign orv = na_q[k] | nb_q[k];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (orv[NW-1 -: SA] == '0) begin
          na_q[k+1] <= na_q[k] << SA;
          nb_q[k+1] <= nb_q[k] << SA;
        end else begin
          na_q[k+1] <= na_q[k];
          nb_q[k+1] <= nb_q[k];
        end
        ns_q[k+1] <= ns_q[k];
      end
    end
  end

  // cordic vectoring, one iteration per stage
  for (genvar i = 0; i < ST; i++) begin : g_cordic
    logic signed [XW-1:0] xin, yin;
    logic signed [ZW-1:0] zin;
    qte_pkg::atan_side_t  sin;
    if (i == 0) begin : g_first
      assign xin = XW'(nb_q[NS][NW-1 -: NB]);
      assign yin = XW'(na_q[NS][NW-1 -: NB]);
      assign zin = '0;
      assign sin = ns_q[NS];
    end else begin : g_next
      assign xin = cx_q[i-1];
      assign yin = cy_q[i-1];
      assign zin = cz_q[i-1];
      assign sin = cs_q[i-1];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (yin > 0) begin
          cx_q[i] <= xin + (yin >>> i);
          cy_q[i] <= yin - (xin >>> i);
          cz_q[i] <= zin + ZW'(qte_pkg::ATAN_TAB[i]);
        end else begin
          cx_q[i] <= xin - (yin >>> i);
          cy_q[i] <= yin + (xin >>> i);
          cz_q[i] <= zin - ZW'(qte_pkg::ATAN_TAB[i]);
        end
        cs_q[i] <= sin;
      end
    end
  end

  // quadrant restore
  always_comb begin
    zq_d = cz_q[ST-1];
    if (cs_q[ST-1].sb) begin
      zq_d = ZW'(qte_pkg::PI_Q16) - zq_d;
    end
    if (cs_q[ST-1].sa) begin
      zq_d = -zq_d;
    end
    if (cs_q[ST-1].zero) begin
      zq_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zq_q <= zq_d;
      qs_q <= cs_q[ST-1];
    end
  end

  // sign, doubling and rounding to q12
  always_comb begin
    v = VW'(zq_q);
    if (qs_q.neg) begin
      v = -v;
    end
    if (qs_q.dbl) begin
      v = v <<< 1;
    end
    r = (v + VW'(8)) >>> 4;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ang_q <= r[qte_pkg::ANG_W-1:0];
    end
  end

  assign angle_o = ang_q;

endmodule

[src/qte_isqrt.sv]
// pipelined integer square root, one root bit per stage, with a side payload
module qte_isqrt #(
  parameter int RW     = 31,
  parameter int SIDE_W = 32
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [2*RW-2:0]     rad_i,
  input  logic [SIDE_W-1:0]   side_i,
  output logic [RW-1:0]       root_o,
  output logic [SIDE_W-1:0]   side_o
);

  localparam int TW = 2 * RW + 1;

  logic [TW-1:0]     rem_q  [RW];
  logic [RW-1:0]     root_q [RW];
  logic [SIDE_W-1:0] side_q [RW];

  for (genvar j = 0; j < RW; j++) begin : g_bit
    localparam int I = RW - 1 - j;
    logic [TW-1:0]     rin, trial;
    logic [RW-1:0]     qin;
    logic [SIDE_W-1:0] sin;
    if (j == 0) begin : g_first
      assign rin = TW'(rad_i);
      assign qin = '0;
      assign sin = side_i;
    end else begin : g_next
      assign rin = rem_q[j-1];
      assign qin = root_q[j-1];
      assign sin = side_q[j-1];
    end
    assign trial = (TW'(qin) << (I + 1)) + (TW'(1) << (2 * I));
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rin >= trial) begin
          rem_q[j]  <= rin - trial;
          root_q[j] <= qin | (RW'(1) << I);
        end else begin
          rem_q[j]  <= rin;
          root_q[j] <= qin;
        end
        side_q[j] <= sin;
      end
    end
  end

  assign root_o = root_q[RW-1];
  assign side_o = side_q[RW-1];

endmodule

[src/qte_skid.sv]
// two-entry output buffer that frees the pipeline from the downstream ready
module qte_skid (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_vld_i,
  input  qte_pkg::result_t in_data_i,
  output logic             en_o,
  output logic             out_vld_o,
  output qte_pkg::result_t out_data_o,
  input  logic             out_ready_i
);

  `include "assert_macros.svh"

  logic             out_vld_q, skid_vld_q;
  qte_pkg::result_t out_q, skid_q;
  logic             take;

  assign en_o = !skid_vld_q;
  assign take = !out_vld_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (take) begin
      if (skid_vld_q) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end else begin
        out_vld_q <= in_vld_i;
      end
    end else if (in_vld_i && !skid_vld_q) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= skid_vld_q ? skid_q : in_data_i;
    end else if (!skid_vld_q) begin
      skid_q <= in_data_i;
    end
  end

  assign out_vld_o  = out_vld_q;
  assign out_data_o = out_q;

  `QTE_ASSERT_IMP(a_skid_behind_out, skid_vld_q, out_vld_q, "skid entry without output entry")
  `QTE_ASSERT_IMP(a_skid_fill_on_stall, skid_vld_q && !$past(skid_vld_q), $past(out_vld_q && !out_ready_i), "skid filled without a stall")

endmodule

[src/quaternion_to_euler_angles.sv]
// Quaternion to euler angle converter. One item (x, y, z, w, signed q2.14) enters per cycle
// and leaves as roll and yaw in signed q4.12 radians and pitch in signed q2.12 radians,
// plus a pole flag. The pitch path, through the 31-stage square root that feeds the pitch
// atan2, is the longest, and yaw and roll are delayed to meet pitch. Each of the three
// atan2 units is a 16-stage cordic behind a leading-one normalizer. A two-entry output
// buffer holds results while the receiver stalls; the input stops only once both entries
// are full. Threshold writes take effect at once.
module quaternion_to_euler_angles #(
  parameter int QUAT_FRAC_BITS = qte_pkg::QUAT_FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [13:0] cfg_data_i,    // pole_threshold
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // quat_x, quat_y, quat_z, quat_w
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // roll_angle, pitch_angle, yaw_angle, zero fill
  output logic [1:0]  m_axis_tuser   // pole_case
);

  `include "assert_macros.svh"

  localparam int F     = QUAT_FRAC_BITS;
  localparam int TST_W = 33;
  localparam int CW    = qte_pkg::max_int(15 + F, 34) + 1;
  localparam int OW    = qte_pkg::max_int(2 * F + 2, 35);
  localparam int SW    = 48;
  localparam int SH    = 2 * F - 30;
  localparam int S30_W = qte_pkg::S30_W;
  localparam int RAD_W = qte_pkg::RAD_W;
  localparam int LYR   = qte_pkg::atan_lat(OW);
  localparam int LP    = qte_pkg::atan_lat(S30_W);
  localparam int L     = 5 + qte_pkg::ROOT_W + LP;
  localparam int D     = L - 2 - LYR;
  localparam int PCD   = L - 1;
  localparam logic signed [OW-1:0] ONE_V = OW'(1) <<< (2 * F);
  localparam logic signed [SW-1:0] ONE30 = SW'(1) <<< 30;

  logic [qte_pkg::CFG_W-1:0] pt_q;
  logic                      en;
  logic                      vld_q [L];

  logic signed [15:0] qx, qy, qz, qw;
  logic signed [31:0] yz_q, xw_q, zw_q, yx_q, zz_q, xx_q, yw_q, zx_q, yy_q;
  logic signed [15:0] y1_q, w1_q;

  logic signed [TST_W-1:0] test_c, test2_q;
  logic signed [CW-1:0]    test_x, thr_x;
  qte_pkg::pole_case_e     pc_c;
  logic signed [OW-1:0]    ya_c, yb_c;
  logic signed [OW-1:0]    ya2_q, yb2_q, ra2_q, rb2_q;
  logic                    ydbl2_q, yneg2_q;
  qte_pkg::pole_case_e     pc_dl_q [PCD];

  logic signed [SW-1:0]    s_ext, s_sh, s_sat;
  logic signed [S30_W-1:0] s30_3_q, s30_4_q, s30_5_q;
  logic signed [2*S30_W-1:0] sq_c;
  logic [RAD_W-1:0]        sq4_q, rad5_q;
  logic [qte_pkg::ROOT_W-1:0] root;
  logic [S30_W-1:0]        s30_side;

  logic signed [15:0] yaw_a, roll_a, pitch_a;
  logic signed [15:0] yaw_dl_q [D];
  logic signed [15:0] roll_dl_q [D];

  qte_pkg::result_t   res_c, res_o;

  // configuration register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pt_q <= qte_pkg::POLE_THRESHOLD_RST;
    end else if (cfg_valid_i) begin
      pt_q <= cfg_data_i;
    end
  end

  assign s_axis_tready = en;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < L; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else if (en) begin
      vld_q[0] <= s_axis_tvalid;
      for (int k = 1; k < L; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // stage 1: products
  assign qx = $signed(s_axis_tdata[15:0]);
  assign qy = $signed(s_axis_tdata[31:16]);
  assign qz = $signed(s_axis_tdata[47:32]);
  assign qw = $signed(s_axis_tdata[63:48]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      yz_q <= qy * qz;
      xw_q <= qx * qw;
      zw_q <= qz * qw;
      yx_q <= qy * qx;
      zz_q <= qz * qz;
      xx_q <= qx * qx;
      yw_q <= qy * qw;
      zx_q <= qz * qx;
      yy_q <= qy * qy;
      y1_q <= qy;
      w1_q <= qw;
    end
  end

  // stage 2: pole test and atan2 operands
  assign test_c = TST_W'(yz_q) + TST_W'(xw_q);
  assign test_x = CW'(test_c);
  assign thr_x  = $signed(CW'(pt_q) << F);

  always_comb begin
    if (test_x > thr_x) begin
      pc_c = qte_pkg::POLE_NORTH;
    end else if (test_x < -thr_x) begin
      pc_c = qte_pkg::POLE_SOUTH;
    end else begin
      pc_c = qte_pkg::POLE_NONE;
    end
    if (pc_c == qte_pkg::POLE_NONE) begin
      ya_c = (OW'(zw_q) - OW'(yx_q)) <<< 1;
      yb_c = ONE_V - ((OW'(zz_q) + OW'(xx_q)) <<< 1);
    end else begin
      ya_c = OW'(y1_q);
      yb_c = OW'(w1_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      test2_q    <= test_c;
      pc_dl_q[0] <= pc_c;
      for (int k = 1; k < PCD; k++) begin
        pc_dl_q[k] <= pc_dl_q[k-1];
      end
      ya2_q      <= ya_c;
      yb2_q      <= yb_c;
      ydbl2_q    <= (pc_c != qte_pkg::POLE_NONE);
      yneg2_q    <= (pc_c == qte_pkg::POLE_SOUTH);
      ra2_q      <= (OW'(yw_q) - OW'(zx_q)) <<< 1;
      rb2_q      <= ONE_V - ((OW'(yy_q) + OW'(xx_q)) <<< 1);
    end
  end

  // stage 3: asin argument in q30, rounded when shifted down, and saturated
  assign s_ext = SW'(test2_q) <<< 1;
  if (SH > 0) begin : g_round
    assign s_sh = (s_ext + (SW'(1) <<< (SH - 1))) >>> SH;
  end else begin : g_widen
    assign s_sh = s_ext <<< (-SH);
  end

  always_comb begin
    s_sat = s_sh;
    if (s_sh > ONE30) begin
      s_sat = ONE30;
    end
    if (s_sh < -ONE30) begin
      s_sat = -ONE30;
    end
  end

  assign sq_c = s30_3_q * s30_3_q;

  // stages 3 to 5: square and radicand
  always_ff @(posedge clk_i) begin
    if (en) begin
      s30_3_q <= S30_W'(s_sat);
      s30_4_q <= s30_3_q;
      sq4_q   <= sq_c[RAD_W-1:0];
      s30_5_q <= s30_4_q;
      rad5_q  <= (RAD_W'(1) << (RAD_W - 1)) - sq4_q;
    end
  end

  qte_isqrt #(
    .RW     (qte_pkg::ROOT_W),
    .SIDE_W (S30_W)
  ) u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (rad5_q),
    .side_i (s30_5_q),
    .root_o (root),
    .side_o (s30_side)
  );

  qte_atan2 #(
    .IN_W (S30_W)
  ) u_atan_pitch (
    .clk_i   (clk_i),
    .en_i    (en),
    .a_i     ($signed(s30_side)),
    .b_i     ($signed(S30_W'(root))),
    .dbl_i   (1'b0),
    .neg_i   (1'b0),
    .angle_o (pitch_a)
  );

  qte_atan2 #(
    .IN_W (OW)
  ) u_atan_yaw (
    .clk_i   (clk_i),
    .en_i    (en),
    .a_i     (ya2_q),
    .b_i     (yb2_q),
    .dbl_i   (ydbl2_q),
    .neg_i   (yneg2_q),
    .angle_o (yaw_a)
  );

  qte_atan2 #(
    .IN_W (OW)
  ) u_atan_roll (
    .clk_i   (clk_i),
    .en_i    (en),
    .a_i     (ra2_q),
    .b_i     (rb2_q),
    .dbl_i   (1'b0),
    .neg_i   (1'b0),
    .angle_o (roll_a)
  );

  // align yaw and roll with pitch
  always_ff @(posedge clk_i) begin
    if (en) begin
      yaw_dl_q[0]  <= yaw_a;
      roll_dl_q[0] <= roll_a;
      for (int k = 1; k < D; k++) begin
        yaw_dl_q[k]  <= yaw_dl_q[k-1];
        roll_dl_q[k] <= roll_dl_q[k-1];
      end
    end
  end

  always_comb begin
    res_c.pcase = pc_dl_q[PCD-1];
    res_c.yaw   = yaw_dl_q[D-1];
    case (pc_dl_q[PCD-1])
      qte_pkg::POLE_NORTH: begin
        res_c.roll  = '0;
        res_c.pitch = qte_pkg::PITCH_W'(qte_pkg::HALF_PI_Q12);
      end
      qte_pkg::POLE_SOUTH: begin
        res_c.roll  = '0;
        res_c.pitch = qte_pkg::PITCH_W'(-qte_pkg::HALF_PI_Q12);
      end
      default: begin
        res_c.roll  = roll_dl_q[D-1];
        res_c.pitch = pitch_a[qte_pkg::PITCH_W-1:0];
      end
    endcase
  end

  qte_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_vld_i    (vld_q[L-1]),
    .in_data_i   (res_c),
    .en_o        (en),
    .out_vld_o   (m_axis_tvalid),
    .out_data_o  (res_o),
    .out_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = {2'b00, res_o.yaw, res_o.pitch, res_o.roll};
  assign m_axis_tuser = res_o.pcase;

  `QTE_ASSERT_IMP(a_pole_roll_zero, m_axis_tvalid && (m_axis_tuser != qte_pkg::POLE_NONE), m_axis_tdata[15:0] == 16'd0, "roll not zero at a pole")
  `QTE_ASSERT_IMP(a_north_pitch, m_axis_tvalid && (m_axis_tuser == qte_pkg::POLE_NORTH), m_axis_tdata[29:16] == qte_pkg::PITCH_W'(qte_pkg::HALF_PI_Q12), "north pole pitch wrong")

endmodule

[bench/quaternion_to_euler_angles_checker.sv]
// checker for the quaternion to euler angle converter: predicts each item and compares
module quaternion_to_euler_angles_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [13:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [47:0] m_axis_tdata,
  input  logic [1:0]  m_axis_tuser,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    qte_pkg::pole_case_e pcase;
    logic signed [15:0]  yaw;
    logic signed [13:0]  pitch;
    logic signed [15:0]  roll;
  } angles_t;

  angles_t     angle_q[$];
  logic [13:0] threshold;
  int          fails;

  assign fail_count_o = fails;
  assign pending_o    = angle_q.size();

  function automatic longint arctan_q16(longint a, longint b);
    longint ua, ub, xr, yr, zr, dx, dy;
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    zr = 0;
    if (ua == 0 && ub == 0) return 0;
    while ((ua | ub) >= (64'sd1 << 30)) begin
      ua = ua >>> 1;
      ub = ub >>> 1;
    end
    while ((ua | ub) < (64'sd1 << 29)) begin
      ua = ua <<< 1;
      ub = ub <<< 1;
    end
    xr = ub;
    yr = ua;
    for (int i = 0; i < qte_pkg::CORDIC_STEPS; i++) begin
      dx = yr >>> i;
      dy = xr >>> i;
      if (yr > 0) begin
        xr += dx;
        yr -= dy;
        zr += qte_pkg::ATAN_TAB[i];
      end else begin
        xr -= dx;
        yr += dy;
        zr -= qte_pkg::ATAN_TAB[i];
      end
    end
    if (b < 0) zr = qte_pkg::PI_Q16 - zr;
    if (a < 0) zr = -zr;
    return zr;
  endfunction

  function automatic longint to_q12(longint v);
    return (v + 8) >>> 4;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic angles_t convert_quat(logic [63:0] d, logic [13:0] thr_cfg);
    longint  qx, qy, qz, qw, tst, thr, s30;
    longint unsigned c;
    angles_t r;
    qx  = longint'($signed(d[15:0]));
    qy  = longint'($signed(d[31:16]));
    qz  = longint'($signed(d[47:32]));
    qw  = longint'($signed(d[63:48]));
    tst = qy * qz + qx * qw;
    thr = longint'(thr_cfg) << 14;
    if (tst > thr) begin
      r.yaw   = 16'(to_q12(2 * arctan_q16(qy, qw)));
      r.pitch = 14'(qte_pkg::HALF_PI_Q12);
      r.roll  = '0;
      r.pcase = qte_pkg::POLE_NORTH;
    end else if (tst < -thr) begin
      r.yaw   = 16'(to_q12(-2 * arctan_q16(qy, qw)));
      r.pitch = 14'(-qte_pkg::HALF_PI_Q12);
      r.roll  = '0;
      r.pcase = qte_pkg::POLE_SOUTH;
    end else begin
      r.yaw  = 16'(to_q12(arctan_q16(2 * (qz * qw - qy * qx),
                                     (64'sd1 << 28) - 2 * (qz * qz + qx * qx))));
      r.roll = 16'(to_q12(arctan_q16(2 * (qy * qw - qz * qx),
                                     (64'sd1 << 28) - 2 * (qy * qy + qx * qx))));
      s30 = (2 * tst) <<< 2;
      if (s30 > (64'sd1 << 30)) s30 = 64'sd1 << 30;
      if (s30 < -(64'sd1 << 30)) s30 = -(64'sd1 << 30);
      c = floor_sqrt((64'd1 << 60) - longint'(s30 * s30));
      r.pitch = 14'(to_q12(arctan_q16(s30, longint'(c))));
      r.pcase = qte_pkg::POLE_NONE;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    angles_t e, got;
    if (!rst_ni) begin
      threshold <= qte_pkg::POLE_THRESHOLD_RST;
      fails     <= 0;
      angle_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) threshold <= cfg_data_i;
      if (s_axis_tvalid && s_axis_tready)
        angle_q = {angle_q, convert_quat(s_axis_tdata, threshold)};
      if (m_axis_tvalid && m_axis_tready) begin
        got.roll  = m_axis_tdata[15:0];
        got.pitch = m_axis_tdata[29:16];
        got.yaw   = m_axis_tdata[45:30];
        got.pcase = qte_pkg::pole_case_e'(m_axis_tuser);
        if (angle_q.size() == 0) begin
          $error("result item with no expectation waiting");
          fails <= fails + 1;
        end else begin
          e = angle_q.pop_front();
          if (got != e || m_axis_tdata[47:46] != 2'b00) begin
            fails <= fails + 1;
            if (got.roll != e.roll)
              $error("roll_angle expected %0d actual %0d", e.roll, got.roll);
            if (got.pitch != e.pitch)
              $error("pitch_angle expected %0d actual %0d", e.pitch, got.pitch);
            if (got.yaw != e.yaw)
              $error("yaw_angle expected %0d actual %0d", e.yaw, got.yaw);
            if (got.pcase != e.pcase)
              $error("pole_case expected %0d actual %0d", e.pcase, got.pcase);
            if (m_axis_tdata[47:46] != 2'b00)
              $error("zero fill expected 0 actual %0d", m_axis_tdata[47:46]);
          end
        end
      end
    end
  end

endmodule

[bench/quaternion_to_euler_angles_tb.sv]
// testbench top for the quaternion to euler angle converter: stimulus and verdict
module quaternion_to_euler_angles_tb;

  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [13:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;   // quat_x, quat_y, quat_z, quat_w
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;        // roll_angle, pitch_angle, yaw_angle, zero fill
  logic [1:0]  m_axis_tuser;        // pole_case
  int          fail_count;
  int          pending;
  int          idle_cycles = 0;
  int          ready_cyc = 0;
  int          burst_left = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  quaternion_to_euler_angles u_top (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  quaternion_to_euler_angles_checker u_checker (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // receiver stall pattern that steps through four modes in turn
  always @(posedge clk_i) begin
    ready_cyc <= ready_cyc + 1;
    case ((ready_cyc / 512) % 4)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 1) == 1);
      2: m_axis_tready <= ((ready_cyc % 7) < 3);
      default: m_axis_tready <= ($urandom_range(0, 9) != 0);
    endcase
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || pending == 0)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic [15:0] rand_comp();
    int k;
    k = $urandom_range(0, 19);
    if (k == 0) return 16'($urandom);
    if (k < 6) return 16'($signed($urandom_range(0, 32768)) - 16384) >>> $urandom_range(1, 10);
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  task automatic quat_item(input logic [15:0] qx, qy, qz, qw);
    logic hs;
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 20);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {qw, qz, qy, qx};
    do begin
      @(negedge clk_i);
      hs = s_axis_tready;
      @(posedge clk_i);
    end while (!hs);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [13:0] v);
    logic hs;
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do begin
      @(negedge clk_i);
      hs = cfg_ready_o;
      @(posedge clk_i);
    end while (!hs);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_run(input int n);
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) drain();
      quat_item(rand_comp(), rand_comp(), rand_comp(), rand_comp());
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    quat_item(16'sd0, 16'sd0, 16'sd0, 16'sd0);
    quat_item(16'sd0, 16'sd0, 16'sd0, 16'sd16384);
    quat_item(16'sd16384, 16'sd0, 16'sd0, 16'sd0);
    quat_item(-16'sd16384, 16'sd0, 16'sd0, 16'sd0);
    quat_item(16'sd0, 16'sd16384, 16'sd0, 16'sd0);
    quat_item(16'sd0, 16'sd0, -16'sd16384, 16'sd0);
    quat_item(16'sd0, 16'sd0, 16'sd0, -16'sd16384);
    quat_item(16'sd11585, 16'sd0, 16'sd0, 16'sd11585);
    quat_item(16'sd11585, 16'sd0, 16'sd0, -16'sd11585);
    quat_item(16'sd0, 16'sd11585, 16'sd11585, 16'sd0);
    quat_item(16'sd0, 16'sd11585, -16'sd11585, 16'sd0);
    quat_item(16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192);
    quat_item(16'sd8192, -16'sd8192, 16'sd8192, -16'sd8192);
    quat_item(16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384);
    quat_item(-16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384);
    quat_item(16'sd16384, -16'sd16384, 16'sd16384, -16'sd16384);
    quat_item(16'sd8190, 16'sd0, 16'sd0, 16'sd16380);
    quat_item(16'sd1, 16'sd0, 16'sd0, 16'sd0);
    quat_item(16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
    random_run(700);
    write_threshold(14'd0);
    quat_item(16'sd0, 16'sd0, 16'sd0, 16'sd0);
    quat_item(16'sd1, 16'sd0, 16'sd0, 16'sd1);
    quat_item(-16'sd1, 16'sd0, 16'sd0, 16'sd1);
    random_run(300);
    write_threshold(14'd8192);
    quat_item(16'sd16384, 16'sd0, 16'sd0, 16'sd8192);
    quat_item(16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384);
    random_run(400);
    write_threshold(14'($urandom_range(0, 8192)));
    random_run(300);
    write_threshold(14'd8190);
    random_run(300);
    drain();
    repeat (80) @(posedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

[quaternion_to_euler_angles.f]
+incdir+src
src/qte_pkg.sv
src/qte_atan2.sv
src/qte_isqrt.sv
src/qte_skid.sv
src/quaternion_to_euler_angles.sv
bench/quaternion_to_euler_angles_checker.sv
bench/quaternion_to_euler_angles_tb.sv
